// File: design/fptt_pkg.sv
// fptt_pkg: shared types and codes of the fee priority transaction table.
// Used by the front, queue, back, top level and checker. No dependencies.
package fptt_pkg;

    localparam logic [2:0] FUNC_INSERT = 3'd0;
    localparam logic [2:0] FUNC_ERASE  = 3'd1;
    localparam logic [2:0] FUNC_LOOKUP = 3'd2;
    localparam logic [2:0] FUNC_LIST   = 3'd3;
    localparam logic [2:0] FUNC_COUNTS = 3'd4;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_DUPLICATE = 3'd1;
    localparam logic [2:0] STATUS_NOT_FOUND = 3'd2;
    localparam logic [2:0] STATUS_FULL      = 3'd3;
    localparam logic [2:0] STATUS_EMPTY     = 3'd4;

    // floored inputs/outputs ratio; zero outputs sets the top bit
    localparam logic [16:0] RATIO_MAX = 17'h10000;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] id;
        logic [63:0] fee;
        logic [31:0] size;
        logic [63:0] amount;
        logic [16:0] ratio;
        logic [63:0] rtime;
    } cmd_t;

    typedef struct packed {
        logic [63:0] id;
        logic [63:0] fee;
        logic [31:0] size;
        logic [63:0] amount;
        logic [16:0] ratio;
        logic [63:0] rtime;
    } entry_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } push_t;

endpackage

// File: design/fptt_front.sv
// fptt_front: accepts transactions, drops unknown codes, works out the
// inputs/outputs ratio with a bit-serial divider. Depends on fptt_pkg.
module fptt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [2:0]           func,
    input  logic [63:0]          tx_id,
    input  logic [63:0]          fee,
    input  logic [31:0]          size_bytes,
    input  logic [63:0]          amount,
    input  logic [15:0]          input_count,
    input  logic [15:0]          output_count,
    input  logic [63:0]          receive_time,
    input  logic                 q_full,
    output fptt_pkg::push_t      q_push
);

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

    fstate_t        state_reg;
    fptt_pkg::cmd_t cmd_reg;
    logic [15:0]    rem_reg;
    logic [15:0]    quo_reg;
    logic [15:0]    div_reg;
    logic [3:0]     cnt_reg;
    logic [16:0]    rem_sh;
    logic [15:0]    rem_next;
    logic [15:0]    quo_next;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[15]};
        if (rem_sh >= {1'b0, div_reg})
        begin
            rem_next = 16'(rem_sh - {1'b0, div_reg});
            quo_next = {quo_reg[14:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh[15:0];
            quo_next = {quo_reg[14:0], 1'b0};
        end
    end

    assign req_stall   = (state_reg != F_IDLE);
    assign q_push.push = (state_reg == F_PUSH) && !q_full;
    assign q_push.cmd  = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cmd_reg   <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            div_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (req_valid && func <= fptt_pkg::FUNC_COUNTS)
                    begin
                        cmd_reg.func   <= func;
                        cmd_reg.id     <= tx_id;
                        cmd_reg.fee    <= fee;
                        cmd_reg.size   <= size_bytes;
                        cmd_reg.amount <= amount;
                        cmd_reg.rtime  <= receive_time;
                        cmd_reg.ratio  <= fptt_pkg::RATIO_MAX;
                        if (func == fptt_pkg::FUNC_INSERT && output_count != 16'd0)
                        begin
                            rem_reg   <= '0;
                            quo_reg   <= input_count;
                            div_reg   <= output_count;
                            cnt_reg   <= '0;
                            state_reg <= F_DIV;
                        end
                        else
                        begin
                            state_reg <= F_PUSH;
                        end
                    end
                end
                F_DIV:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                    begin
                        cmd_reg.ratio <= {1'b0, quo_next};
                        state_reg     <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!q_full)
                        state_reg <= F_IDLE;
                end
                default:
                    state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

// File: design/fptt_queue.sv
// fptt_queue: two-entry command queue between front and back.
// Depends on fptt_pkg.
module fptt_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  fptt_pkg::push_t    q_push,
    output logic               q_full,
    output logic               q_valid,
    output fptt_pkg::cmd_t     q_cmd,
    input  logic               q_pop
);

    fptt_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;

    assign q_full  = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (q_push.push)
            slot_reg[wr_ptr_reg] <= q_push.cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (q_push.push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (q_push.push && !q_pop)
                count_reg <= count_reg + 2'd1;
            else if (q_pop && !q_push.push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// File: design/fptt_back.sv
// fptt_back: sorted entry memory and the sequencer that searches, compares,
// shifts and lists entries, with the result register. Depends on fptt_pkg.
module fptt_back #(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  fptt_pkg::cmd_t     q_cmd,
    output logic               q_pop,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [2:0]         status,
    output logic [63:0]        out_tx_id,
    output logic [63:0]        out_fee,
    output logic [63:0]        out_receive_time,
    output logic               zero_fee,
    output logic [6:0]         total_count,
    output logic [6:0]         fee_free_count,
    output logic               last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        B_IDLE, B_FIND_RD, B_FIND_CHK, B_MISS, B_POS_RD, B_POS_M0, B_POS_M1,
        B_POS_CMP, B_SH_RD, B_SH_WR, B_ER_RD, B_ER_WR, B_ER_DONE, B_WR_NEW,
        B_EMIT, B_LS_EMIT
    } bstate_t;

    fptt_pkg::entry_t mem [DEPTH];
    fptt_pkg::entry_t rd_data_reg;

    bstate_t          state_reg;
    fptt_pkg::cmd_t   cmd_reg;
    fptt_pkg::entry_t slot_reg;
    logic [CW-1:0]    idx_reg;
    logic [CW-1:0]    pos_reg;
    logic [AW-1:0]    addr_reg;
    logic [CW-1:0]    held_reg;
    logic [CW-1:0]    free_reg;
    logic             zf_reg;
    logic [63:0]      pa0_reg, pa1_reg, pb0_reg, pb1_reg;
    logic [2:0]       res_status_reg;
    logic [63:0]      res_id_reg;
    logic [63:0]      res_fee_reg;
    logic [63:0]      res_time_reg;
    logic             res_zf_reg;

    logic [2:0]       status_reg;
    logic [63:0]      id_out_reg, fee_out_reg, time_out_reg;
    logic             zf_out_reg, last_out_reg, valid_reg;
    logic [6:0]       total_reg, free_out_reg;

    logic             out_free;
    logic             res_load;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    fptt_pkg::entry_t mem_wdata;
    fptt_pkg::entry_t cand;
    logic [95:0]      prod_c, prod_k;
    logic             prefer;
    logic [CW-1:0]    idx_inc;
    logic [CW:0]      idx_inc2;

    assign out_free = !valid_reg || !rsp_stall;
    assign res_load = out_free && (state_reg == B_EMIT || state_reg == B_LS_EMIT);
    assign q_pop    = (state_reg == B_IDLE) && q_valid;
    assign idx_inc  = CW'(idx_reg + 1'b1);
    assign idx_inc2 = (CW+1)'(idx_reg) + (CW+1)'(2);

    assign cand.id     = cmd_reg.id;
    assign cand.fee    = cmd_reg.fee;
    assign cand.size   = cmd_reg.size;
    assign cand.amount = cmd_reg.amount;
    assign cand.ratio  = cmd_reg.ratio;
    assign cand.rtime  = cmd_reg.rtime;

    assign prod_c = {32'd0, pa0_reg} + {pa1_reg, 32'd0};
    assign prod_k = {32'd0, pb0_reg} + {pb1_reg, 32'd0};

    always_comb
    begin
        if (prod_c != prod_k)
            prefer = prod_c > prod_k;
        else if (cmd_reg.amount != slot_reg.amount)
            prefer = cmd_reg.amount > slot_reg.amount;
        else if (cmd_reg.ratio != slot_reg.ratio)
            prefer = cmd_reg.ratio > slot_reg.ratio;
        else if (cmd_reg.size != slot_reg.size)
            prefer = cmd_reg.size < slot_reg.size;
        else
            prefer = cmd_reg.rtime < slot_reg.rtime;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = AW'(idx_reg);
        mem_wdata = rd_data_reg;
        unique case (state_reg)
            B_SH_WR, B_ER_WR:
                mem_we = 1'b1;
            B_WR_NEW:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(pos_reg);
                mem_wdata = cand;
            end
            default:
                mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[addr_reg];
    end

    assign rsp_valid        = valid_reg;
    assign status           = status_reg;
    assign out_tx_id        = id_out_reg;
    assign out_fee          = fee_out_reg;
    assign out_receive_time = time_out_reg;
    assign zero_fee         = zf_out_reg;
    assign total_count      = total_reg;
    assign fee_free_count   = free_out_reg;
    assign last             = last_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            cmd_reg        <= '0;
            slot_reg       <= '0;
            idx_reg        <= '0;
            pos_reg        <= '0;
            addr_reg       <= '0;
            held_reg       <= '0;
            free_reg       <= '0;
            zf_reg         <= 1'b0;
            pa0_reg        <= '0;
            pa1_reg        <= '0;
            pb0_reg        <= '0;
            pb1_reg        <= '0;
            res_status_reg <= fptt_pkg::STATUS_OK;
            res_id_reg     <= '0;
            res_fee_reg    <= '0;
            res_time_reg   <= '0;
            res_zf_reg     <= 1'b0;
            valid_reg      <= 1'b0;
            status_reg     <= fptt_pkg::STATUS_OK;
            id_out_reg     <= '0;
            fee_out_reg    <= '0;
            time_out_reg   <= '0;
            zf_out_reg     <= 1'b0;
            last_out_reg   <= 1'b0;
            total_reg      <= '0;
            free_out_reg   <= '0;
        end
        else
        begin
            if (res_load)
                valid_reg <= 1'b1;
            else if (!rsp_stall)
                valid_reg <= 1'b0;

            unique case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg        <= q_cmd;
                        idx_reg        <= '0;
                        addr_reg       <= '0;
                        res_status_reg <= fptt_pkg::STATUS_OK;
                        res_id_reg     <= '0;
                        res_fee_reg    <= '0;
                        res_time_reg   <= '0;
                        res_zf_reg     <= 1'b0;
                        unique case (q_cmd.func)
                            fptt_pkg::FUNC_INSERT, fptt_pkg::FUNC_ERASE,
                            fptt_pkg::FUNC_LOOKUP:
                                state_reg <= (held_reg == '0) ? B_MISS : B_FIND_RD;
                            fptt_pkg::FUNC_LIST:
                            begin
                                if (held_reg == '0)
                                begin
                                    res_status_reg <= fptt_pkg::STATUS_EMPTY;
                                    state_reg      <= B_EMIT;
                                end
                                else
                                begin
                                    state_reg <= B_FIND_RD;
                                end
                            end
                            default:
                                state_reg <= B_EMIT;
                        endcase
                    end
                end
                B_FIND_RD:
                    state_reg <= (cmd_reg.func == fptt_pkg::FUNC_LIST) ? B_LS_EMIT
                                                                       : B_FIND_CHK;
                B_FIND_CHK:
                begin
                    if (rd_data_reg.id == cmd_reg.id)
                    begin
                        zf_reg  <= (rd_data_reg.fee == 64'd0);
                        pos_reg <= idx_reg;
                        unique case (cmd_reg.func)
                            fptt_pkg::FUNC_INSERT:
                            begin
                                res_status_reg <= fptt_pkg::STATUS_DUPLICATE;
                                res_id_reg     <= cmd_reg.id;
                                state_reg      <= B_EMIT;
                            end
                            fptt_pkg::FUNC_LOOKUP:
                            begin
                                res_id_reg   <= rd_data_reg.id;
                                res_fee_reg  <= rd_data_reg.fee;
                                res_time_reg <= rd_data_reg.rtime;
                                res_zf_reg   <= (rd_data_reg.fee == 64'd0);
                                state_reg    <= B_EMIT;
                            end
                            default:
                            begin
                                if (idx_inc < held_reg)
                                begin
                                    addr_reg  <= AW'(idx_inc);
                                    state_reg <= B_ER_RD;
                                end
                                else
                                begin
                                    state_reg <= B_ER_DONE;
                                end
                            end
                        endcase
                    end
                    else if (idx_inc == held_reg)
                    begin
                        state_reg <= B_MISS;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        addr_reg  <= AW'(idx_inc);
                        state_reg <= B_FIND_RD;
                    end
                end
                B_MISS:
                begin
                    if (cmd_reg.func == fptt_pkg::FUNC_INSERT)
                    begin
                        res_id_reg <= cmd_reg.id;
                        if (held_reg >= CW'(DEPTH))
                        begin
                            res_status_reg <= fptt_pkg::STATUS_FULL;
                            state_reg      <= B_EMIT;
                        end
                        else if (held_reg == '0)
                        begin
                            pos_reg   <= '0;
                            state_reg <= B_WR_NEW;
                        end
                        else
                        begin
                            idx_reg   <= '0;
                            addr_reg  <= '0;
                            state_reg <= B_POS_RD;
                        end
                    end
                    else
                    begin
                        res_status_reg <= fptt_pkg::STATUS_NOT_FOUND;
                        state_reg      <= B_EMIT;
                    end
                end
                B_POS_RD:
                    state_reg <= B_POS_M0;
                B_POS_M0:
                begin
                    slot_reg  <= rd_data_reg;
                    pa0_reg   <= cmd_reg.fee[31:0] * rd_data_reg.size;
                    pb0_reg   <= rd_data_reg.fee[31:0] * cmd_reg.size;
                    state_reg <= B_POS_M1;
                end
                B_POS_M1:
                begin
                    pa1_reg   <= cmd_reg.fee[63:32] * slot_reg.size;
                    pb1_reg   <= slot_reg.fee[63:32] * cmd_reg.size;
                    state_reg <= B_POS_CMP;
                end
                B_POS_CMP:
                begin
                    if (prefer)
                    begin
                        pos_reg   <= idx_reg;
                        idx_reg   <= held_reg;
                        addr_reg  <= AW'(held_reg - 1'b1);
                        state_reg <= B_SH_RD;
                    end
                    else if (idx_inc == held_reg)
                    begin
                        pos_reg   <= held_reg;
                        state_reg <= B_WR_NEW;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        addr_reg  <= AW'(idx_inc);
                        state_reg <= B_POS_RD;
                    end
                end
                B_SH_RD:
                    state_reg <= B_SH_WR;
                B_SH_WR:
                begin
                    idx_reg <= CW'(idx_reg - 1'b1);
                    if (CW'(idx_reg - 1'b1) == pos_reg)
                    begin
                        state_reg <= B_WR_NEW;
                    end
                    else
                    begin
                        addr_reg  <= AW'(idx_reg - CW'(2));
                        state_reg <= B_SH_RD;
                    end
                end
                B_ER_RD:
                    state_reg <= B_ER_WR;
                B_ER_WR:
                begin
                    idx_reg <= idx_inc;
                    if (idx_inc2 < (CW+1)'(held_reg))
                    begin
                        addr_reg  <= AW'(idx_inc2);
                        state_reg <= B_ER_RD;
                    end
                    else
                    begin
                        state_reg <= B_ER_DONE;
                    end
                end
                B_ER_DONE:
                begin
                    held_reg  <= CW'(held_reg - 1'b1);
                    free_reg  <= CW'(free_reg - CW'(zf_reg));
                    state_reg <= B_EMIT;
                end
                B_WR_NEW:
                begin
                    held_reg  <= CW'(held_reg + 1'b1);
                    free_reg  <= CW'(free_reg + CW'(cmd_reg.fee == 64'd0));
                    state_reg <= B_EMIT;
                end
                B_EMIT:
                begin
                    if (out_free)
                    begin
                        status_reg   <= res_status_reg;
                        id_out_reg   <= res_id_reg;
                        fee_out_reg  <= res_fee_reg;
                        time_out_reg <= res_time_reg;
                        zf_out_reg   <= res_zf_reg;
                        last_out_reg <= 1'b1;
                        total_reg    <= 7'(held_reg);
                        free_out_reg <= 7'(free_reg);
                        state_reg    <= B_IDLE;
                    end
                end
                B_LS_EMIT:
                begin
                    if (out_free)
                    begin
                        status_reg   <= fptt_pkg::STATUS_OK;
                        id_out_reg   <= rd_data_reg.id;
                        fee_out_reg  <= rd_data_reg.fee;
                        time_out_reg <= rd_data_reg.rtime;
                        zf_out_reg   <= (rd_data_reg.fee == 64'd0);
                        last_out_reg <= (idx_inc == held_reg);
                        total_reg    <= 7'(held_reg);
                        free_out_reg <= 7'(free_reg);
                        if (idx_inc == held_reg)
                        begin
                            state_reg <= B_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_inc;
                            addr_reg  <= AW'(idx_inc);
                            state_reg <= B_FIND_RD;
                        end
                    end
                end
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

// File: design/fee_priority_transaction_table.sv
// Fee priority transaction table, top level: front, queue and back.
// Insert, erase, lookup and list step through the held entries one at a time over the
// slot memory's single read and write port; an insert with zero outputs skips the divider.
// The front and the back each handle one transaction at a time.
// Reset clears the entry count; slot contents stay undefined until written.
module fee_priority_transaction_table #(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  func,
    input  logic [63:0] tx_id,
    input  logic [63:0] fee,
    input  logic [31:0] size_bytes,
    input  logic [63:0] amount,
    input  logic [15:0] input_count,
    input  logic [15:0] output_count,
    input  logic [63:0] receive_time,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [2:0]  status,
    output logic [63:0] out_tx_id,
    output logic [63:0] out_fee,
    output logic [63:0] out_receive_time,
    output logic        zero_fee,
    output logic [6:0]  total_count,
    output logic [6:0]  fee_free_count,
    output logic        last
);

    fptt_pkg::push_t q_push;
    fptt_pkg::cmd_t  q_cmd;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;

    fptt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .func         (func),
        .tx_id        (tx_id),
        .fee          (fee),
        .size_bytes   (size_bytes),
        .amount       (amount),
        .input_count  (input_count),
        .output_count (output_count),
        .receive_time (receive_time),
        .q_full       (q_full),
        .q_push       (q_push)
    );

    fptt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    fptt_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_cmd            (q_cmd),
        .q_pop            (q_pop),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .status           (status),
        .out_tx_id        (out_tx_id),
        .out_fee          (out_fee),
        .out_receive_time (out_receive_time),
        .zero_fee         (zero_fee),
        .total_count      (total_count),
        .fee_free_count   (fee_free_count),
        .last             (last)
    );

endmodule

// File: design/fptt_checker.sv
// fptt_checker: port-level checks of the transaction table, bound to the
// top level. Depends on fptt_pkg.
module fptt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [2:0]  status,
    input logic [63:0] out_tx_id,
    input logic        zero_fee,
    input logic [6:0]  total_count,
    input logic [6:0]  fee_free_count,
    input logic        last
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(out_tx_id)
            && $stable(last))
        else $error("result changed while stalled");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != fptt_pkg::STATUS_OK |-> last && !zero_fee)
        else $error("error result not final");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == fptt_pkg::STATUS_EMPTY |-> total_count == 7'd0)
        else $error("empty reported with entries held");

    a_free_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> fee_free_count <= total_count)
        else $error("fee-free count above total");

endmodule

bind fee_priority_transaction_table fptt_checker u_fptt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .out_tx_id      (out_tx_id),
    .zero_fee       (zero_fee),
    .total_count    (total_count),
    .fee_free_count (fee_free_count),
    .last           (last)
);
